// File: hdl/kdebg_pkg.sv
// shared types and constants for the kde background score block
package kdebg_pkg;
    localparam logic [1:0] CMD_STORE    = 2'd0;
    localparam logic [1:0] CMD_EVAL     = 2'd1;
    localparam logic [1:0] CMD_LOAD     = 2'd2;
    localparam logic [1:0] CMD_RSVD     = 2'd3;
    localparam int         SUM_W        = 24;
    localparam int         FRAME_PIXELS = 65536;
    localparam int         PIX_W        = $clog2(FRAME_PIXELS);

    typedef enum logic [2:0] {
        t_ST_IDLE,
        t_ST_READ,
        t_ST_KRD,
        t_ST_ACC,
        t_ST_DIV,
        t_ST_DONE
    } t_state;

    typedef struct packed {
        logic latch;
        logic store;
        logic load;
        logic clr_acc;
        logic rd;
        logic krd;
        logic acc;
        logic next_slot;
        logic div_start;
        logic emit;
    } t_ctl_cmd;

    typedef struct packed {
        logic last_slot;
        logic ready_hist;
        logic div_done;
    } t_ctl_sts;
endpackage

// File: hdl/kdebg_ctrl.sv
// controller state machine sequencing store, load and evaluate items
module kdebg_ctrl
    import kdebg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_cmd,
    input  t_ctl_sts   i_sts,
    output t_ctl_cmd   o_cmd,
    output logic       o_busy
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= t_ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = (r_state != t_ST_IDLE);
        unique case (r_state)
            t_ST_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    if (i_cmd == CMD_STORE) o_cmd.store = 1'b1;
                    if (i_cmd == CMD_LOAD)  o_cmd.load  = 1'b1;
                    if (i_cmd == CMD_EVAL) begin
                        o_cmd.clr_acc = 1'b1;
                        n_state = t_ST_READ;
                    end
                end
            end
            t_ST_READ: begin
                if (i_sts.ready_hist) begin
                    o_cmd.rd = 1'b1;
                    n_state  = t_ST_KRD;
                end else begin
                    n_state = t_ST_DONE;
                end
            end
            t_ST_KRD: begin
                o_cmd.krd = 1'b1;
                n_state   = t_ST_ACC;
            end
            t_ST_ACC: begin
                o_cmd.acc = 1'b1;
                if (i_sts.last_slot) begin
                    o_cmd.div_start = 1'b1;
                    n_state = t_ST_DIV;
                end else begin
                    o_cmd.next_slot = 1'b1;
                    n_state = t_ST_READ;
                end
            end
            t_ST_DIV: begin
                if (i_sts.div_done) n_state = t_ST_DONE;
            end
            t_ST_DONE: begin
                o_cmd.emit = 1'b1;
                n_state = t_ST_IDLE;
            end
            default: n_state = t_ST_IDLE;
        endcase
    end

    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> r_state == t_ST_IDLE)
        else $error("emit not followed by idle");
    a_krd_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd |=> o_cmd.krd)
        else $error("read not followed by kernel lookup");
    a_acc_after_krd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.krd |=> o_cmd.acc)
        else $error("kernel lookup not followed by accumulate");
    a_busy_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clr_acc |=> o_busy)
        else $error("evaluate did not go busy");
endmodule

// File: hdl/kdebg_div.sv
// restoring divider, one quotient bit per cycle, for three channel sums
module kdebg_div
    import kdebg_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SUM_W-1:0] i_num [3],
    input  logic [SUM_W-1:0] i_den,
    output logic             o_done,
    output logic [7:0]       o_q [3]
);
    localparam int CW = $clog2(SUM_W + 1);
    logic [SUM_W-1:0] r_n [3];
    logic [SUM_W-1:0] r_q [3];
    logic [SUM_W:0]   r_r [3];
    logic [SUM_W-1:0] r_d;
    logic [CW-1:0]    r_cnt;
    logic             r_run;
    logic [SUM_W:0]   w_t [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_t[c] = {r_r[c][SUM_W-1:0], r_n[c][SUM_W-1]};
            o_q[c] = (|r_q[c][SUM_W-1:8]) ? 8'hff : r_q[c][7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= '0;
        end else if (i_start) begin
            r_run <= 1'b1;
            r_cnt <= CW'(SUM_W);
        end else if (r_run) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) r_run <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_d <= i_den;
            for (int c = 0; c < 3; c++) begin
                r_n[c] <= i_num[c] + (i_den >> 1);
                r_r[c] <= '0;
                r_q[c] <= '0;
            end
        end else if (r_run) begin
            for (int c = 0; c < 3; c++) begin
                r_n[c] <= r_n[c] << 1;
                if (w_t[c] >= {1'b0, r_d}) begin
                    r_r[c] <= w_t[c] - {1'b0, r_d};
                    r_q[c] <= {r_q[c][SUM_W-2:0], 1'b1};
                end else begin
                    r_r[c] <= w_t[c];
                    r_q[c] <= {r_q[c][SUM_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_done = r_run && (r_cnt == CW'(1));
endmodule

// File: hdl/kdebg_dp.sv
// datapath: history memory, kernel table, ring state and accumulators
module kdebg_dp
    import kdebg_pkg::*;
#(
    parameter int MAX_DEPTH = 8,
    parameter int FRAC      = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_ctl_cmd         i_cmd,
    input  logic             i_cfg_wr,
    input  logic [3:0]       i_depth,
    input  logic [15:0]      i_pixel_index,
    input  logic [7:0]       i_red,
    input  logic [7:0]       i_green,
    input  logic [7:0]       i_blue,
    input  logic             i_last_pixel,
    input  logic [7:0]       i_kernel_index,
    input  logic [15:0]      i_kernel_value,
    output t_ctl_sts         o_sts,
    output logic [15:0]      o_score_index,
    output logic [7:0]       o_score_red,
    output logic [7:0]       o_score_green,
    output logic [7:0]       o_score_blue,
    output logic             o_ready_res,
    output logic             o_valid
);
    localparam int SW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int KW = $clog2(MAX_DEPTH + 1);
    localparam int AW = SW + PIX_W;

    logic [23:0] r_hist [2**AW];
    logic [15:0] r_ktab_r [256];
    logic [15:0] r_ktab_g [256];
    logic [15:0] r_ktab_b [256];
    logic [SW-1:0] r_wslot, r_rslot;
    logic [KW-1:0] r_frames;
    logic          r_full;
    logic [15:0]   r_pix;
    logic [7:0]    r_ch [3];
    logic [23:0]   r_word;
    logic [15:0]   r_kv [3];
    logic [SUM_W-1:0] r_sum [3];
    logic [SUM_W-1:0] w_nsum [3];
    logic [7:0]    w_q [3];
    logic          w_ddone;
    logic [KW-1:0] w_k;
    logic [SUM_W-1:0] w_den;
    logic [7:0]    w_st [3];
    logic [7:0]    w_ad [3];
    logic [AW-1:0] w_waddr, w_raddr;
    logic [KW-1:0] w_fr_inc;
    logic          r_ready_res;

    always_comb begin
        if (i_depth == 4'd0)                  w_k = KW'(1);
        else if (32'(i_depth) > MAX_DEPTH)    w_k = KW'(MAX_DEPTH);
        else                                  w_k = KW'(i_depth);
        w_den = SUM_W'(w_k) << FRAC;
        w_waddr = {r_wslot, i_pixel_index[PIX_W-1:0]};
        w_raddr = {r_rslot, r_pix[PIX_W-1:0]};
        w_fr_inc = (32'(r_frames) < MAX_DEPTH) ? r_frames + 1'b1 : r_frames;
        w_st[0] = r_word[23:16];
        w_st[1] = r_word[15:8];
        w_st[2] = r_word[7:0];
        for (int c = 0; c < 3; c++) begin
            w_ad[c] = (r_ch[c] > w_st[c]) ? r_ch[c] - w_st[c] : w_st[c] - r_ch[c];
            w_nsum[c] = r_sum[c] + SUM_W'(r_kv[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) r_hist[w_waddr] <= {i_red, i_green, i_blue};
        if (i_cmd.rd)    r_word <= r_hist[w_raddr];
    end

    // one copy of the kernel table per channel, each read at one address
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ktab_r[i_kernel_index] <= i_kernel_value;
            r_ktab_g[i_kernel_index] <= i_kernel_value;
            r_ktab_b[i_kernel_index] <= i_kernel_value;
        end
        if (i_cmd.krd) begin
            r_kv[0] <= r_ktab_r[w_ad[0]];
            r_kv[1] <= r_ktab_g[w_ad[1]];
            r_kv[2] <= r_ktab_b[w_ad[2]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr) begin
            r_wslot  <= '0;
            r_frames <= '0;
            r_full   <= 1'b0;
        end else if (i_cmd.store && i_last_pixel) begin
            r_wslot  <= (KW'(r_wslot) + 1'b1 >= w_k) ? '0 : r_wslot + 1'b1;
            r_frames <= w_fr_inc;
            if (w_fr_inc >= w_k) r_full <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_pix   <= i_pixel_index;
            r_ch[0] <= i_red;
            r_ch[1] <= i_green;
            r_ch[2] <= i_blue;
        end
        if (i_cmd.clr_acc) begin
            r_rslot <= '0;
            for (int c = 0; c < 3; c++) r_sum[c] <= '0;
        end else begin
            if (i_cmd.next_slot) r_rslot <= r_rslot + 1'b1;
            if (i_cmd.acc)
                for (int c = 0; c < 3; c++) r_sum[c] <= w_nsum[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ready_res <= 1'b0;
        else if (i_cmd.clr_acc) r_ready_res <= r_full && (r_frames >= w_k);
    end

    kdebg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_nsum),
        .i_den   (w_den),
        .o_done  (w_ddone),
        .o_q     (w_q)
    );

    assign o_sts.last_slot  = (KW'(r_rslot) + 1'b1 >= w_k);
    assign o_sts.ready_hist = r_ready_res;
    assign o_sts.div_done   = w_ddone;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else          o_valid <= i_cmd.emit;
        if (i_cmd.emit) begin
            o_score_index <= r_pix;
            o_ready_res   <= r_ready_res;
            o_score_red   <= r_ready_res ? w_q[0] : 8'd0;
            o_score_green <= r_ready_res ? w_q[1] : 8'd0;
            o_score_blue  <= r_ready_res ? w_q[2] : 8'd0;
        end
    end

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        KW'(r_wslot) < w_k || $past(i_cfg_wr))
        else $error("write slot out of ring");
    a_full_frames: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> r_frames != '0)
        else $error("full with no frames");
    a_frames_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_frames) <= MAX_DEPTH)
        else $error("frame count overflow");
endmodule

// File: hdl/kde_background_score_top.sv
// top level of the kde background score block
// store, load and unknown items stay in idle; busy stays low; no result
// evaluate: per slot a history read, a kernel lookup and an accumulate, then the divider, then done
// when not ready the slot reads are skipped and a zero result is given; next item on the strobe cycle
// throughput set by one history read port per slot and the bit-serial divider; no output stall
// synchronous active-low reset clears ring state; depth resets to 3; memories are not cleared
module kde_background_score_top
    import kdebg_pkg::*;
#(
    parameter int MAX_DEPTH        = 8,
    parameter int KERNEL_FRAC_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [15:0] i_pixel_index,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic        i_last_pixel,
    input  logic [7:0]  i_kernel_index,
    input  logic [15:0] i_kernel_value,
    output logic        o_strobe,
    output logic [15:0] o_score_index,
    output logic [7:0]  o_score_red,
    output logic [7:0]  o_score_green,
    output logic [7:0]  o_score_blue,
    output logic        o_ready_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    t_ctl_cmd   w_cmd;
    t_ctl_sts   w_sts;
    logic [3:0] r_depth;
    logic       w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr == 2'd0);
    assign prdata   = (paddr == 2'd0) ? {28'd0, r_depth} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)     r_depth <= 4'd3;
        else if (w_cfg_wr) r_depth <= pwdata[3:0];
    end

    kdebg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_cmd),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    kdebg_dp #(.MAX_DEPTH(MAX_DEPTH), .FRAC(KERNEL_FRAC_BITS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_cfg_wr       (w_cfg_wr),
        .i_depth        (r_depth),
        .i_pixel_index  (i_pixel_index),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .i_last_pixel   (i_last_pixel),
        .i_kernel_index (i_kernel_index),
        .i_kernel_value (i_kernel_value),
        .o_sts          (w_sts),
        .o_score_index  (o_score_index),
        .o_score_red    (o_score_red),
        .o_score_green  (o_score_green),
        .o_score_blue   (o_score_blue),
        .o_ready_res    (o_ready_res),
        .o_valid        (o_strobe)
    );
endmodule
